FILE: rtl/core/step_rate_tracker_with_backlash_assert.svh
// Assertion shorthands shared by srt_div and step_rate_tracker_with_backlash.
`ifndef STEP_RATE_TRACKER_WITH_BACKLASH_ASSERT_SVH
`define STEP_RATE_TRACKER_WITH_BACKLASH_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define SRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/srt_pkg.sv
package srt_pkg;

    localparam int POS_W  = 32;
    localparam int RATE_W = 32;
    localparam int BRATE_W = 31;
    localparam int BAMT_W = 16;
    localparam int STEP_W = 8;
    localparam int Q_W    = 31;
    localparam int DEN_W  = 33;
    localparam int MUL_W  = 39;

    localparam logic [63:0] PERIOD_SCALE2 = 64'd8192000000;
    localparam logic [63:0] MAG_SPAN      = 64'd4294967296;

    localparam logic ACT_RATE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic CFG_BACKLASH_AMOUNT = 1'b0;
    localparam logic CFG_BACKLASH_RATE   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] target;
        logic signed [POS_W-1:0] taken;
        logic                    in_bl;
    } axis_t;

endpackage

FILE: rtl/core/srt_div.sv
`include "step_rate_tracker_with_backlash_assert.svh"

module srt_div
    import srt_pkg::*;
#(
    parameter int NUM_W = 39
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [Q_W-1:0]   quo
);

    localparam int CNT_W = $clog2(Q_W);
    localparam int HI_W  = NUM_W - Q_W;

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [Q_W-1:0]   shf_reg, shf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, shf_reg[Q_W-1]} - {1'b0, den_reg};
    assign ge    = !trial[DEN_W];

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        shf_next  = shf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {{(DEN_W-HI_W){1'b0}}, num[NUM_W-1:Q_W]};
            shf_next  = num[Q_W-1:0];
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial[DEN_W-1:0] : {rem_reg[DEN_W-2:0], shf_reg[Q_W-1]};
            shf_next = {shf_reg[Q_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(Q_W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        shf_reg <= shf_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = shf_reg;

    `SRT_ASSERT_IMP(a_rem_below_den, clk, rst_n, busy_reg, rem_reg < den_reg)
    `SRT_ASSERT_IMP(a_no_restart, clk, rst_n, start, !busy_reg && !done_reg)

endmodule

FILE: rtl/core/srt_tick.sv
module srt_tick
    import srt_pkg::*;
(
    input  axis_t                    cur,
    input  logic signed [STEP_W-1:0] step_value,
    input  logic                     sync,
    input  logic [BAMT_W-1:0]        backlash_amount,
    output axis_t                    nxt
);

    logic        [STEP_W-1:0] step_abs;
    logic signed [POS_W-1:0]  a;
    logic signed [POS_W-1:0]  amt;
    logic signed [POS_W-1:0]  tgt;
    logic signed [POS_W-1:0]  taken_dn;
    logic signed [POS_W-1:0]  taken_up;

    assign step_abs = step_value[STEP_W-1] ? STEP_W'(-step_value) : step_value;
    assign a        = {{(POS_W-STEP_W){1'b0}}, step_abs};
    assign amt      = {{(POS_W-BAMT_W){1'b0}}, backlash_amount};
    assign tgt      = (sync && !cur.in_bl)
                      ? cur.target + {{(POS_W-STEP_W){step_value[STEP_W-1]}}, step_value}
                      : cur.target;
    assign taken_dn = cur.taken - a;
    assign taken_up = cur.taken + a;

    always_comb
    begin
        nxt        = cur;
        nxt.target = tgt;
        priority if (cur.position > tgt)
        begin
            if (cur.taken > 0)
            begin
                nxt.taken = taken_dn;
                nxt.in_bl = taken_dn > 0;
            end
            else
            begin
                nxt.position = cur.position - a;
                nxt.in_bl    = 1'b0;
            end
        end
        else if (cur.position < tgt || cur.in_bl)
        begin
            if (cur.taken < amt)
            begin
                nxt.taken = taken_up;
                nxt.in_bl = taken_up < amt;
            end
            else
            begin
                nxt.position = cur.position + a;
                nxt.in_bl    = 1'b0;
            end
        end
        else
        begin
            nxt.in_bl = cur.in_bl;
        end
    end

endmodule

FILE: rtl/core/step_rate_tracker_with_backlash.sv
// Stepper position generator with backlash take-up. For a timer tick item the
// position update is plain logic and the result is offered in the cycle after
// acceptance. A rate command item passes a setup state, which picks the step
// size and, if the rate is zero or the period would be out of range, offers a
// zero period and step; otherwise a restoring divider that shares one 34-bit
// subtractor (one quotient bit per cycle) forms the 31-bit rounded tick period,
// and the quotient is latched before the result is offered. The block takes
// no new item until its result has been taken, so output stall delays the next.
`include "step_rate_tracker_with_backlash_assert.svh"

module step_rate_tracker_with_backlash
    import srt_pkg::*;
#(
    parameter int COARSE_STEP = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [BRATE_W-1:0]       cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     action,
    input  logic signed [RATE_W-1:0] rate,
    input  logic                     synchronized,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [POS_W-1:0]  position,
    output logic signed [POS_W-1:0]  target,
    output logic signed [POS_W-1:0]  backlash_count,
    output logic                     taking_up_backlash,
    output logic signed [STEP_W-1:0] signed_step,
    output logic [Q_W-1:0]           tick_period
);

    localparam logic [63:0] PNUM_C64 = PERIOD_SCALE2 * COARSE_STEP;
    localparam int NUM_W = $clog2(PNUM_C64 + MAG_SPAN);
    localparam logic [NUM_W-1:0] PNUM_F = NUM_W'(PERIOD_SCALE2);
    localparam logic [NUM_W-1:0] PNUM_C = NUM_W'(PNUM_C64);
    localparam logic [MUL_W-1:0] LIM_F  = MUL_W'(128);
    localparam logic [MUL_W-1:0] LIM_C  = MUL_W'(128 * COARSE_STEP);
    localparam logic signed [STEP_W-1:0] S_F = STEP_W'(1);
    localparam logic signed [STEP_W-1:0] S_C = STEP_W'(COARSE_STEP);

    state_t                  state_reg, state_next;
    axis_t                   axis_reg, axis_next;
    axis_t                   axis_tick;
    logic [BAMT_W-1:0]       bamt_reg;
    logic [BRATE_W-1:0]      brate_reg;
    logic [RATE_W-1:0]       rate_reg, rate_next;
    logic                    coarse_reg, coarse_next;
    logic signed [STEP_W-1:0] step_reg, step_next;
    logic [Q_W-1:0]          period_reg, period_next;
    logic                    in_accept;

    logic [RATE_W-1:0]       mag_cmd;
    logic [RATE_W-1:0]       mag;
    logic                    fine;
    logic                    coarse_sel;
    logic [MUL_W-1:0]        mag65;
    logic                    period_ok;
    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic                    div_start;
    logic                    div_busy;
    logic                    div_done;
    logic [Q_W-1:0]          div_quo;
    logic signed [STEP_W-1:0] s_cur;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = (state_reg == ST_OUT);

    assign mag_cmd    = rate_reg[RATE_W-1] ? RATE_W'(-rate_reg) : rate_reg;
    assign mag        = axis_reg.in_bl ? {1'b0, brate_reg} : mag_cmd;
    assign fine       = {1'b0, mag} <= {1'b0, brate_reg, 1'b0};
    assign coarse_sel = fine ? 1'b0 : (axis_reg.in_bl ? coarse_reg : 1'b1);
    assign mag65      = {1'b0, mag, 6'b0} + {{(MUL_W-RATE_W){1'b0}}, mag};
    assign period_ok  = (mag != '0) && ((coarse_sel ? LIM_C : LIM_F) <= mag65);
    assign div_num    = (coarse_sel ? PNUM_C : PNUM_F) + {{(NUM_W-RATE_W){1'b0}}, mag};
    assign div_den    = {mag, 1'b0};
    assign div_start  = (state_reg == ST_SETUP) && period_ok;
    assign s_cur      = coarse_reg ? S_C : S_F;

    srt_tick u_tick
    (
        .cur             (axis_reg),
        .step_value      (step_reg),
        .sync            (synchronized),
        .backlash_amount (bamt_reg),
        .nxt             (axis_tick)
    );

    srt_div #(
        .NUM_W (NUM_W)
    ) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        rate_next   = rate_reg;
        coarse_next = coarse_reg;
        step_next   = step_reg;
        period_next = period_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (action == ACT_TICK)
                    begin
                        axis_next  = axis_tick;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        rate_next  = rate;
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                coarse_next = coarse_sel;
                if (period_ok)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    period_next = '0;
                    step_next   = '0;
                    state_next  = ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    period_next = div_quo;
                    if (rate_reg == '0)
                        step_next = '0;
                    else if (rate_reg[RATE_W-1])
                        step_next = -s_cur;
                    else
                        step_next = s_cur;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            axis_reg   <= '0;
            coarse_reg <= 1'b0;
            step_reg   <= '0;
            period_reg <= '0;
            bamt_reg   <= '0;
            brate_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            coarse_reg <= coarse_next;
            step_reg   <= step_next;
            period_reg <= period_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BACKLASH_AMOUNT: bamt_reg  <= cfg_data[BAMT_W-1:0];
                    CFG_BACKLASH_RATE:   brate_reg <= cfg_data;
                    default:             bamt_reg  <= bamt_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg <= rate_next;
    end

    assign position           = axis_reg.position;
    assign target             = axis_reg.target;
    assign backlash_count     = axis_reg.taken;
    assign taking_up_backlash = axis_reg.in_bl;
    assign signed_step        = step_reg;
    assign tick_period        = period_reg;

    `SRT_ASSERT_NXT(a_tick_one_cycle, clk, rst_n, in_accept && action == ACT_TICK, state_reg == ST_OUT)
    `SRT_ASSERT_IMP(a_done_in_div, clk, rst_n, div_done, state_reg == ST_DIV)
    `SRT_ASSERT_IMP(a_busy_in_div, clk, rst_n, div_busy, state_reg == ST_DIV)
    `SRT_ASSERT_IMP(a_step_legal, clk, rst_n, out_valid, step_reg == '0 || step_reg == S_F || step_reg == -S_F || step_reg == S_C || step_reg == -S_C)

endmodule
